@@ hw/rtl/vbp_pkg.sv @@
// Shared types and constants for the variable width bit packer.
// Used by vbp_pack, vbp_out_fifo and variable_width_bit_packer; no dependencies.
`default_nettype none
package vbp_pkg;

  localparam int WORD_WIDTH = 64;
  localparam int VAL_W      = 32;
  localparam int CFG_W      = 6;
  localparam int FILL_W     = 7;
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = 2;
  localparam int CNT_W      = 3;

  localparam logic [CFG_W-1:0] WIDTH_RESET = 6'd8;
  localparam logic [CFG_W-1:0] WIDTH_MIN   = 6'd1;
  localparam logic [CFG_W-1:0] WIDTH_MAX   = 6'd32;

  // One output word with its end-of-stream flag
  typedef struct packed {
    logic [WORD_WIDTH-1:0] word;
    logic                  last;
  } out_word_t;

  // Words produced by one packing step, first word in e0
  typedef struct packed {
    logic [1:0] n;
    out_word_t  e0;
    out_word_t  e1;
  } pack_res_t;

endpackage
`default_nettype wire

@@ hw/rtl/vbp_pack.sv @@
// Packing datapath: accumulator, fill count and the shift-or for one value.
// Depends on vbp_pkg.
`default_nettype none
module vbp_pack (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic [vbp_pkg::CFG_W-1:0] cfg_width,
  input  wire logic                      fire,
  input  wire logic [vbp_pkg::VAL_W-1:0] value,
  input  wire logic                      is_last,
  output vbp_pkg::pack_res_t             res
);
  import vbp_pkg::*;

  logic [WORD_WIDTH-1:0] acc_r, acc_nxt;
  logic [FILL_W-1:0]     fill_r, fill_nxt;

  logic [CFG_W-1:0]            w;
  logic [VAL_W:0]              mask;
  logic [VAL_W-1:0]            v;
  logic [WORD_WIDTH+VAL_W-1:0] sh;
  logic [WORD_WIDTH-1:0]       merged;
  logic [FILL_W-1:0]           total;
  logic                        full;
  logic [WORD_WIDTH-1:0]       acc_step;
  logic [FILL_W-1:0]           fill_step;

  // Clamp the configured width to 1..32 and mask the value
  always_comb begin
    if (cfg_width == '0) begin
      w = WIDTH_MIN;
    end else if (cfg_width > WIDTH_MAX) begin
      w = WIDTH_MAX;
    end else begin
      w = cfg_width;
    end
    mask = ~({(VAL_W+1){1'b1}} << w);
    v    = value & mask[VAL_W-1:0];
  end

  // Place the value above the filled bits; spill goes to the top part
  always_comb begin
    sh        = {{WORD_WIDTH{1'b0}}, v} << fill_r;
    merged    = acc_r | sh[WORD_WIDTH-1:0];
    total     = fill_r + {1'b0, w};
    full      = (total >= FILL_W'(WORD_WIDTH));
    acc_step  = full ? {{(WORD_WIDTH-VAL_W){1'b0}}, sh[WORD_WIDTH+VAL_W-1:WORD_WIDTH]}
                     : merged;
    fill_step = full ? (total - FILL_W'(WORD_WIDTH)) : total;
  end

  // Build the result words and the next state
  always_comb begin
    res          = '0;
    acc_nxt      = acc_step;
    fill_nxt     = fill_step;
    if (full) begin
      res.n       = 2'd1;
      res.e0.word = merged;
    end
    if (is_last) begin
      if (fill_step != '0) begin
        if (full) begin
          res.n       = 2'd2;
          res.e1.word = acc_step;
          res.e1.last = 1'b1;
        end else begin
          res.n       = 2'd1;
          res.e0.word = acc_step;
          res.e0.last = 1'b1;
        end
      end else if (full) begin
        res.e0.last = 1'b1;
      end
      acc_nxt  = '0;
      fill_nxt = '0;
    end
  end

  // Advance the state on each packed value
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      fill_r <= '0;
    end else if (fire) begin
      acc_r  <= acc_nxt;
      fill_r <= fill_nxt;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/vbp_out_fifo.sv @@
// Four-entry output queue taking up to two words a cycle, giving one when out_ready is high.
// Depends on vbp_pkg.
`default_nettype none
module vbp_out_fifo (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      push,
  input  wire vbp_pkg::pack_res_t        res,
  output logic                           room2,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output vbp_pkg::out_word_t             out_word
);
  import vbp_pkg::*;

  out_word_t         mem_r [FIFO_DEPTH];
  logic [PTR_W-1:0]  wr_r, wr_nxt;
  logic [PTR_W-1:0]  rd_r, rd_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [1:0]        n_push;
  logic              pop;

  assign n_push    = push ? res.n : 2'd0;
  assign out_valid = (cnt_r != '0);
  assign pop       = out_valid && out_ready;
  assign out_word  = mem_r[rd_r];
  assign room2     = (cnt_r <= CNT_W'(FIFO_DEPTH - 2));

  // Pointer and count update
  always_comb begin
    wr_nxt  = wr_r + PTR_W'(n_push);
    rd_nxt  = rd_r + PTR_W'(pop);
    cnt_nxt = cnt_r + CNT_W'(n_push) - CNT_W'(pop);
  end

  // Write the entries
  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      mem_r[wr_r] <= res.e0;
    end
    if (n_push == 2'd2) begin
      mem_r[wr_r + PTR_W'(1)] <= res.e1;
    end
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/variable_width_bit_packer.sv @@
// Top level of the variable width bit packer.
// Depends on vbp_pkg, vbp_pack and vbp_out_fifo.
//
// Usage:
//   Input channel (in_valid/in_ready, in_value, in_is_last) takes one value per
//   word. Each value is cut to value_width bits (0 counts as 1, above 32 as 32)
//   and packed LSB first into 64-bit words on the output channel
//   (out_valid/out_ready, out_packed_word, out_last_word). A value marked last
//   flushes any partial word zero-padded, with out_last_word set on the final
//   word of the stream.
//   Configuration channel (cfg_valid/cfg_ready, cfg_value_width) is always
//   ready; write it only while the packer is idle.
// Timing:
//   An accepted value is packed from the input register once the output queue
//   has room for two words, and its words then enter the queue. One value per
//   cycle is sustained while the queue has room, set by the single shift-or on
//   the accumulator; a last value that yields two words writes both at once.
// Reset: accumulator and fill count clear, width returns to 8, queue empties.
// Stall: a four-entry output queue absorbs results; the packing step waits
//   when fewer than two entries are free, and the input register then holds.
`default_nettype none
module variable_width_bit_packer (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [vbp_pkg::VAL_W-1:0]     in_value,
  input  wire logic                          in_is_last,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [vbp_pkg::WORD_WIDTH-1:0]     out_packed_word,
  output logic                               out_last_word,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [vbp_pkg::CFG_W-1:0]     cfg_value_width
);
  import vbp_pkg::*;

  logic [CFG_W-1:0] width_r;
  logic             s1_valid_r;
  logic [VAL_W-1:0] s1_value_r;
  logic             s1_last_r;
  logic             room2;
  logic             fire;
  pack_res_t        res;
  out_word_t        oword;

  assign cfg_ready = 1'b1;
  assign fire      = s1_valid_r && room2;
  assign in_ready  = !s1_valid_r || fire;

  // Width register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= WIDTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      width_r <= cfg_value_width;
    end
  end

  // Input register: advance when empty or when the packing step takes the held word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_value_r <= in_value;
      s1_last_r  <= in_is_last;
    end
  end

  vbp_pack u_pack (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_width (width_r),
    .fire      (fire),
    .value     (s1_value_r),
    .is_last   (s1_last_r),
    .res       (res)
  );

  vbp_out_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fire),
    .res       (res),
    .room2     (room2),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (oword)
  );

  assign out_packed_word = oword.word;
  assign out_last_word   = oword.last;

endmodule
`default_nettype wire

@@ dv/vbp_pack_checker.sv @@
// Checker for the variable width bit packer: watches the input, output and config channels,
// predicts the packed words and compares them. Depends on vbp_pkg.
`timescale 1ns / 1ps
module vbp_pack_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic [vbp_pkg::VAL_W-1:0]      in_value,
  input  logic                           in_is_last,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [vbp_pkg::WORD_WIDTH-1:0] out_packed_word,
  input  logic                           out_last_word,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [vbp_pkg::CFG_W-1:0]      cfg_value_width,
  output int                             fail_count,
  output int                             pending
);
  import vbp_pkg::*;

  // Predicted packer state
  logic [WORD_WIDTH-1:0] acc_bits;
  logic [FILL_W-1:0]     bits_held;
  logic [CFG_W-1:0]      width_reg;
  out_word_t             expected_words[$];

  // Pack one accepted value and queue the words it completes
  task automatic pack_value(input logic [VAL_W-1:0] value, input logic is_last);
    int                    w;
    int                    total;
    int                    rem;
    int                    n;
    logic [WORD_WIDTH-1:0] v;
    out_word_t             made[2];
    // clamp the width: zero packs one bit, anything above 32 packs 32
    if (width_reg == '0) begin
      w = 1;
    end else if (width_reg > WIDTH_MAX) begin
      w = WIDTH_MAX;
    end else begin
      w = width_reg;
    end
    v = '0;
    v[VAL_W-1:0] = value;
    v = v & ((64'd1 << w) - 64'd1);
    acc_bits = acc_bits | (v << bits_held);
    total = bits_held + w;
    n = 0;
    // emit the full word, carry the high part of a straddling value
    if (total >= WORD_WIDTH) begin
      made[0].word = acc_bits;
      made[0].last = 1'b0;
      n = 1;
      rem = total - WORD_WIDTH;
      acc_bits = (rem > 0) ? (v >> (w - rem)) : '0;
      bits_held = rem[FILL_W-1:0];
    end else begin
      bits_held = total[FILL_W-1:0];
    end
    // flush a partial word, or mark the exact-fill word as final
    if (is_last) begin
      if (bits_held != '0) begin
        made[n].word = acc_bits;
        made[n].last = 1'b1;
        n++;
      end else if (n > 0) begin
        made[n-1].last = 1'b1;
      end
      acc_bits = '0;
      bits_held = '0;
    end
    for (int i = 0; i < n; i++) expected_words.push_back(made[i]);
  endtask

  // Compare one delivered word against the oldest prediction
  task automatic check_word();
    out_word_t exp_w;
    if (expected_words.size() == 0) begin
      $display("%0t: unexpected word %h last %b", $time, out_packed_word, out_last_word);
      fail_count++;
    end else begin
      exp_w = expected_words.pop_front();
      if (out_packed_word !== exp_w.word) begin
        $display("%0t: packed_word expected %h actual %h", $time, exp_w.word,
                 out_packed_word);
        fail_count++;
      end
      if (out_last_word !== exp_w.last) begin
        $display("%0t: last_word expected %b actual %b", $time, exp_w.last, out_last_word);
        fail_count++;
      end
    end
  endtask

  // Track all three channels at each edge
  always @(posedge clk) begin
    if (!rst_n) begin
      acc_bits = '0;
      bits_held = '0;
      width_reg = WIDTH_RESET;
      expected_words.delete();
      fail_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) width_reg = cfg_value_width;
      if (in_valid && in_ready) pack_value(in_value, in_is_last);
      if (out_valid && out_ready) check_word();
    end
    pending <= expected_words.size();
  end

endmodule

@@ dv/tb_variable_width_bit_packer.sv @@
// Top of the bit packer testbench: clock, reset, stimulus and verdict.
// Depends on vbp_pkg, variable_width_bit_packer and vbp_pack_checker.
`timescale 1ns / 1ps
module tb_variable_width_bit_packer;
  import vbp_pkg::*;

  localparam int LIMIT_CYCLES = 300000;
  localparam int SETTLE       = 8;
  localparam int HOLD_CYCLES  = 400;
  localparam int PHASE_ITEMS  = 240;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [VAL_W-1:0]      in_value = '0;
  logic                  in_is_last = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [WORD_WIDTH-1:0] out_packed_word;
  logic                  out_last_word;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_W-1:0]      cfg_value_width = '0;

  int fail_count;
  int pending_words;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;
  logic hold_req = 1'b0;
  logic hold_taken = 1'b0;
  int cycle_count;

  variable_width_bit_packer DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_value        (in_value),
    .in_is_last      (in_is_last),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_packed_word (out_packed_word),
    .out_last_word   (out_last_word),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_value_width (cfg_value_width)
  );

  vbp_pack_checker u_pack_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_value        (in_value),
    .in_is_last      (in_is_last),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_packed_word (out_packed_word),
    .out_last_word   (out_last_word),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_value_width (cfg_value_width),
    .fail_count      (fail_count),
    .pending         (pending_words)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Receiver: random stalls, plus one long hold-off when requested
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_taken) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_taken <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Stop a hung run
  initial begin
    for (cycle_count = 0; cycle_count < LIMIT_CYCLES; cycle_count++) @(posedge clk);
    $display("Simulation FAILED");
    $finish;
  end

  // Offer one word, idling first at the sender's rate, and hold it until taken
  task automatic push_value(input logic [VAL_W-1:0] value, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_value <= value;
    in_is_last <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Drop valid, wait out every predicted word and the pipeline behind it
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_width(input logic [CFG_W-1:0] w);
    cfg_valid <= 1'b1;
    cfg_value_width <= w;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly legal widths, sometimes zero or out of range
  function automatic logic [CFG_W-1:0] pick_width();
    int r;
    r = $urandom_range(19);
    if (r == 0) return '0;
    if (r == 1) return CFG_W'($urandom_range(33, 63));
    if (r == 2) return WIDTH_MAX;
    if (r < 8) return CFG_W'($urandom_range(1, 6));
    return CFG_W'($urandom_range(1, 32));
  endfunction

  function automatic logic [VAL_W-1:0] pick_value();
    int r;
    r = $urandom_range(15);
    if (r == 0) return '1;
    if (r == 1) return '0;
    return $urandom;
  endfunction

  // Send one stream ending in a last word, maybe changing width partway
  task automatic run_stream(output int sent);
    int len;
    int change_at;
    len = $urandom_range(1, 48);
    change_at = ($urandom_range(3) == 0) ? $urandom_range(0, len - 1) : -1;
    settle();
    set_width(pick_width());
    for (int i = 0; i < len; i++) begin
      if (i == change_at && i != 0) begin
        settle();
        set_width(pick_width());
      end
      push_value(pick_value(), i == len - 1);
    end
    sent = len;
  endtask

  initial begin
    int sent;
    int total;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset width 8: eight values fill one word exactly, the last one closes it
    push_value(32'hFFFF_FFFF, 1'b0);
    push_value(32'h0000_0000, 1'b0);
    push_value(32'h1234_56A5, 1'b0);
    push_value(32'hFFFF_FF00, 1'b0);
    push_value(32'h0000_0081, 1'b0);
    push_value(32'h8000_007F, 1'b0);
    push_value(32'h5555_5555, 1'b0);
    push_value(32'hAAAA_AAAA, 1'b1);

    // zero width packs single bits; flush a partial word
    settle();
    set_width('0);
    push_value(32'hFFFF_FFFF, 1'b0);
    push_value(32'h0000_0000, 1'b0);
    push_value(32'hFFFF_FFFD, 1'b1);

    // width above 32 clamps: two values fill one word exactly, then a partial flush
    settle();
    set_width(6'd63);
    push_value(32'hFFFF_FFFF, 1'b0);
    push_value(32'h0000_0001, 1'b0);
    push_value(32'hA5A5_A5A5, 1'b1);

    // a straddling value: the last one yields a full word and a flushed one
    settle();
    set_width(6'd31);
    push_value(32'hFFFF_FFFF, 1'b0);
    push_value(32'h7FFF_FFFE, 1'b0);
    push_value(32'hC000_0003, 1'b1);

    settle();
    set_width(WIDTH_MAX);
    push_value(32'h8000_0001, 1'b1);
    settle();
    set_width(WIDTH_MIN);
    push_value(32'h0000_0001, 1'b1);

    // width change in the middle of a stream keeps the held bits
    settle();
    set_width(6'd5);
    push_value(32'h0000_001F, 1'b0);
    push_value(32'hFFFF_FFE0, 1'b0);
    push_value(32'h0000_0015, 1'b0);
    settle();
    set_width(6'd20);
    push_value(32'hFFFF_FFFF, 1'b0);
    push_value(32'h000A_BCDE, 1'b0);
    push_value(32'h0008_0001, 1'b1);

    // random streams across the idling mixes
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
        1: begin send_idle_pct = 59; recv_stall_pct <= 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct <= 59; end
        default: begin send_idle_pct = 11; recv_stall_pct <= 11; end
      endcase
      total = 0;
      while (total < PHASE_ITEMS) begin
        run_stream(sent);
        total += sent;
      end
    end

    // long receiver hold-off while the sender keeps pushing
    settle();
    send_idle_pct = 0;
    recv_stall_pct <= 0;
    hold_req <= 1'b1;
    total = 0;
    while (total < 70) begin
      run_stream(sent);
      total += sent;
    end

    settle();
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/vbp_pkg.sv
hw/rtl/vbp_pack.sv
hw/rtl/vbp_out_fifo.sv
hw/rtl/variable_width_bit_packer.sv
dv/vbp_pack_checker.sv
dv/tb_variable_width_bit_packer.sv
